// ----- hw/rtl/mcsm_pkg.sv -----
// ----------------------------------------------------------------------------
// mcsm_pkg
// Shared types and constants of the motion command source multiplexer.
// ----------------------------------------------------------------------------
package mcsm_pkg;

    localparam int VelW    = 32;
    localparam int TimeW   = 32;
    localparam int NumSrc  = 4;
    localparam int NumAxes = 6;
    localparam int SrcW    = $clog2(NumSrc);

    localparam logic [TimeW-1:0] TimeoutReset = TimeW'(350);

    typedef logic [TimeW-1:0]              t_time;
    typedef logic [NumAxes-1:0][VelW-1:0]  t_vec;

    typedef enum logic [2:0] {
        OP_SAMPLE   = 3'd0,
        OP_MODE     = 3'd1,
        OP_RECOVERY = 3'd2,
        OP_SAFETY   = 3'd3,
        OP_PUBLISH  = 3'd4
    } t_opcode;

    typedef enum logic [2:0] {
        MODE_STOP     = 3'd0,
        MODE_MANUAL   = 3'd1,
        MODE_AUTO     = 3'd2,
        MODE_NAV      = 3'd3,
        MODE_RECOVERY = 3'd4
    } t_mode;

    typedef enum logic [2:0] {
        SRC_STOP     = 3'd0,
        SRC_SAFETY   = 3'd1,
        SRC_MANUAL   = 3'd2,
        SRC_AUTO     = 3'd3,
        SRC_NAV      = 3'd4,
        SRC_RECOVERY = 3'd5
    } t_source;

    typedef enum logic [2:0] {
        RSN_STOP_MODE    = 3'd0,
        RSN_SAFETY       = 3'd1,
        RSN_SELECTED     = 3'd2,
        RSN_STALE_ZERO   = 3'd3,
        RSN_STALE        = 3'd4,
        RSN_RECOVERY_OFF = 3'd5
    } t_reason;

    typedef enum logic [1:0] {
        REG_TIMEOUT           = 2'd0,
        REG_REPORT_STALE_ZERO = 2'd1,
        REG_SAFETY_ZERO       = 2'd2,
        REG_RECOVERY_ACT      = 2'd3
    } t_reg;

    localparam logic [SrcW-1:0] RecoverySrc = SrcW'(NumSrc - 1);

    typedef struct packed {
        t_time timeout_ms;
        logic  report_stale_zero;
        logic  safety_forces_zero;
        logic  recovery_needs_active;
    } t_cfg;

    typedef struct packed {
        logic [2:0]         opcode;
        t_time              time_now;
        logic [SrcW-1:0]    source_index;
        t_vec               vel;
        logic [NumAxes-1:0] nonfinite_mask;
        logic [2:0]         mode_value;
        logic               flag_value;
    } t_cmd;

    typedef struct packed {
        logic            sel_valid;
        logic [SrcW-1:0] sel_index;
        logic [2:0]      source_code;
        logic [2:0]      reason_code;
        logic            stale_flag;
    } t_decision;

    function automatic logic is_fresh(input logic seen, input t_time stamp,
                                      input t_time now, input t_time timeout);
        t_time age;
        age = now - stamp;
        return seen && ((timeout == '0) || (age <= timeout));
    endfunction

endpackage

// ----- hw/rtl/mcsm_cmd_if.sv -----
// ----------------------------------------------------------------------------
// mcsm_cmd_if
// Input item channel: valid/ready handshake with the command item fields.
// ----------------------------------------------------------------------------
interface mcsm_cmd_if
    import mcsm_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [2:0]         opcode;
    t_time              time_now;
    logic [SrcW-1:0]    source_index;
    logic signed [VelW-1:0] lin_x;
    logic signed [VelW-1:0] lin_y;
    logic signed [VelW-1:0] lin_z;
    logic signed [VelW-1:0] ang_x;
    logic signed [VelW-1:0] ang_y;
    logic signed [VelW-1:0] ang_z;
    logic [NumAxes-1:0] nonfinite_mask;
    logic [2:0]         mode_value;
    logic               flag_value;

    modport source (
        output valid, opcode, time_now, source_index, lin_x, lin_y, lin_z,
               ang_x, ang_y, ang_z, nonfinite_mask, mode_value, flag_value,
        input  ready
    );

    modport sink (
        input  valid, opcode, time_now, source_index, lin_x, lin_y, lin_z,
               ang_x, ang_y, ang_z, nonfinite_mask, mode_value, flag_value,
        output ready
    );
endinterface

// ----- hw/rtl/mcsm_res_if.sv -----
// ----------------------------------------------------------------------------
// mcsm_res_if
// Result channel: valid/ready handshake with the selected command and codes.
// ----------------------------------------------------------------------------
interface mcsm_res_if
    import mcsm_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic signed [VelW-1:0] out_lin_x;
    logic signed [VelW-1:0] out_lin_y;
    logic signed [VelW-1:0] out_lin_z;
    logic signed [VelW-1:0] out_ang_x;
    logic signed [VelW-1:0] out_ang_y;
    logic signed [VelW-1:0] out_ang_z;
    logic [2:0]             source_code;
    logic [2:0]             reason_code;
    logic                   stale_flag;
    logic                   safety_level;
    logic                   recovery_level;

    modport source (
        output valid, out_lin_x, out_lin_y, out_lin_z, out_ang_x, out_ang_y,
               out_ang_z, source_code, reason_code, stale_flag, safety_level,
               recovery_level,
        input  ready
    );

    modport sink (
        input  valid, out_lin_x, out_lin_y, out_lin_z, out_ang_x, out_ang_y,
               out_ang_z, source_code, reason_code, stale_flag, safety_level,
               recovery_level,
        output ready
    );
endinterface

// ----- hw/rtl/mcsm_select.sv -----
// ----------------------------------------------------------------------------
// mcsm_select
// Publish decision: picks the source for the current mode and applies the
// safety, freshness and recovery-active rules.
// ----------------------------------------------------------------------------
module mcsm_select
    import mcsm_pkg::*;
(
    input  t_cfg                i_cfg,
    input  t_time               i_now,
    input  logic [2:0]          i_mode,
    input  logic [NumSrc-1:0]   i_seen,
    input  t_time [NumSrc-1:0]  i_stamp,
    input  logic                i_rec_flag,
    input  logic                i_rec_seen,
    input  t_time               i_rec_stamp,
    input  logic                i_saf_flag,
    input  logic                i_saf_seen,
    input  t_time               i_saf_stamp,
    output t_decision           o_dec
);

    logic            safety_hit;
    logic            mode_active;
    logic [SrcW-1:0] src;
    logic            allowed;
    logic            cmd_recent;

    always_comb begin
        safety_hit  = i_cfg.safety_forces_zero && i_saf_flag
                      && is_fresh(i_saf_seen, i_saf_stamp, i_now, i_cfg.timeout_ms);
        mode_active = (i_mode >= MODE_MANUAL) && (i_mode <= MODE_RECOVERY);
        src         = SrcW'(i_mode - 3'd1);
        allowed     = 1'b1;
        if (src == RecoverySrc && i_cfg.recovery_needs_active) begin
            allowed = i_rec_flag
                      && is_fresh(i_rec_seen, i_rec_stamp, i_now, i_cfg.timeout_ms);
        end
        cmd_recent = is_fresh(i_seen[src], i_stamp[src], i_now, i_cfg.timeout_ms);
    end

    always_comb begin
        o_dec = '0;
        o_dec.sel_index = src;
        priority if (safety_hit) begin
            o_dec.source_code = SRC_SAFETY;
            o_dec.reason_code = RSN_SAFETY;
        end else if (mode_active) begin
            o_dec.source_code = i_mode + 3'd1;
            priority if (!allowed) begin
                o_dec.reason_code = RSN_RECOVERY_OFF;
                o_dec.stale_flag  = 1'b1;
            end else if (cmd_recent) begin
                o_dec.reason_code = RSN_SELECTED;
                o_dec.sel_valid   = 1'b1;
            end else begin
                o_dec.reason_code = i_cfg.report_stale_zero ? RSN_STALE_ZERO : RSN_STALE;
                o_dec.stale_flag  = 1'b1;
            end
        end else begin
            o_dec.source_code = SRC_STOP;
            o_dec.reason_code = RSN_STOP_MODE;
        end
    end

endmodule

// ----- hw/rtl/motion_command_source_mux_top.sv -----
// ----------------------------------------------------------------------------
// motion_command_source_mux_top
// Velocity command multiplexer with per-source freshness timeout.
// ----------------------------------------------------------------------------
// Items enter on i_cmd: command samples, mode sets, recovery and safety flag
// updates, and publish requests. Only a publish produces a result on o_res:
// the command of the source that the mode selects, or zero, with source,
// reason and stale codes. Configuration registers are written through the
// APB port while the block is idle; the user must keep to this, as the
// block itself does not enforce it. An item is taken into an input register,
// decided by compare-and-select logic, and a publish result lands in the
// output register. One item is accepted every cycle unless a publish waits
// in the input register while a stalled receiver holds the output register.
// A new item is accepted while a result waits; the input register holds the
// next item until the output register frees, so a stalled receiver stops
// the input only once both registers are full. Non-publish items never wait.
// Reset marks all samples unseen, clears the flags, sets the mode to stop
// and loads the defaults: timeout 350 ms and all three policy bits set.
// ----------------------------------------------------------------------------
module motion_command_source_mux_top
    import mcsm_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    mcsm_cmd_if.sink           i_cmd,
    mcsm_res_if.source         o_res,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    t_cfg r_cfg;

    logic r_in_valid;
    t_cmd r_in;

    logic [NumSrc-1:0][NumAxes-1:0][VelW-1:0] r_vel;
    t_time [NumSrc-1:0] r_stamp;
    logic  [NumSrc-1:0] r_seen;
    logic  [2:0]        r_mode;
    logic               r_rec_flag;
    logic               r_rec_seen;
    t_time              r_rec_stamp;
    logic               r_saf_flag;
    logic               r_saf_seen;
    t_time              r_saf_stamp;

    logic  r_out_valid;
    t_vec  r_out_vel;
    logic [2:0] r_out_source;
    logic [2:0] r_out_reason;
    logic  r_out_stale;
    logic  r_out_saf;
    logic  r_out_rec;

    t_decision dec;
    logic      is_pub;
    logic      advance;
    logic      cfg_wr;
    t_vec      in_vel;
    t_reg      reg_sel;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_sel = t_reg'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.timeout_ms            <= TimeoutReset;
            r_cfg.report_stale_zero     <= 1'b1;
            r_cfg.safety_forces_zero    <= 1'b1;
            r_cfg.recovery_needs_active <= 1'b1;
        end else if (cfg_wr) begin
            unique case (reg_sel)
                REG_TIMEOUT:           r_cfg.timeout_ms            <= pwdata[TimeW-1:0];
                REG_REPORT_STALE_ZERO: r_cfg.report_stale_zero     <= pwdata[0];
                REG_SAFETY_ZERO:       r_cfg.safety_forces_zero    <= pwdata[0];
                REG_RECOVERY_ACT:      r_cfg.recovery_needs_active <= pwdata[0];
                default:               r_cfg <= r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_TIMEOUT:           prdata = r_cfg.timeout_ms;
            REG_REPORT_STALE_ZERO: prdata = {31'd0, r_cfg.report_stale_zero};
            REG_SAFETY_ZERO:       prdata = {31'd0, r_cfg.safety_forces_zero};
            REG_RECOVERY_ACT:      prdata = {31'd0, r_cfg.recovery_needs_active};
            default:               prdata = '0;
        endcase
    end

    assign is_pub      = (r_in.opcode == OP_PUBLISH);
    assign advance     = r_in_valid && (!is_pub || !r_out_valid || o_res.ready);
    assign i_cmd.ready = !r_in_valid || advance;

    assign in_vel = {i_cmd.ang_z, i_cmd.ang_y, i_cmd.ang_x,
                     i_cmd.lin_z, i_cmd.lin_y, i_cmd.lin_x};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_cmd.ready) begin
            r_in_valid <= i_cmd.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.valid && i_cmd.ready) begin
            r_in.opcode         <= i_cmd.opcode;
            r_in.time_now       <= i_cmd.time_now;
            r_in.source_index   <= i_cmd.source_index;
            r_in.vel            <= in_vel;
            r_in.nonfinite_mask <= i_cmd.nonfinite_mask;
            r_in.mode_value     <= i_cmd.mode_value;
            r_in.flag_value     <= i_cmd.flag_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in.opcode == OP_SAMPLE) begin
            for (int a = 0; a < NumAxes; a++) begin
                r_vel[r_in.source_index][a] <=
                    r_in.nonfinite_mask[a] ? '0 : r_in.vel[a];
            end
            r_stamp[r_in.source_index] <= r_in.time_now;
        end
        if (advance && r_in.opcode == OP_RECOVERY) begin
            r_rec_stamp <= r_in.time_now;
        end
        if (advance && r_in.opcode == OP_SAFETY) begin
            r_saf_stamp <= r_in.time_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen     <= '0;
            r_mode     <= MODE_STOP;
            r_rec_flag <= 1'b0;
            r_rec_seen <= 1'b0;
            r_saf_flag <= 1'b0;
            r_saf_seen <= 1'b0;
        end else if (advance) begin
            priority case (r_in.opcode)
                OP_SAMPLE: begin
                    r_seen[r_in.source_index] <= 1'b1;
                end
                OP_MODE: begin
                    r_mode <= r_in.mode_value;
                end
                OP_RECOVERY: begin
                    r_rec_flag <= r_in.flag_value;
                    r_rec_seen <= 1'b1;
                end
                OP_SAFETY: begin
                    r_saf_flag <= r_in.flag_value;
                    r_saf_seen <= 1'b1;
                end
                default: begin
                    r_mode <= r_mode;
                end
            endcase
        end
    end

    mcsm_select u_select (
        .i_cfg       (r_cfg),
        .i_now       (r_in.time_now),
        .i_mode      (r_mode),
        .i_seen      (r_seen),
        .i_stamp     (r_stamp),
        .i_rec_flag  (r_rec_flag),
        .i_rec_seen  (r_rec_seen),
        .i_rec_stamp (r_rec_stamp),
        .i_saf_flag  (r_saf_flag),
        .i_saf_seen  (r_saf_seen),
        .i_saf_stamp (r_saf_stamp),
        .o_dec       (dec)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && is_pub) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && is_pub) begin
            r_out_vel    <= dec.sel_valid ? r_vel[dec.sel_index] : '0;
            r_out_source <= dec.source_code;
            r_out_reason <= dec.reason_code;
            r_out_stale  <= dec.stale_flag;
            r_out_saf    <= r_saf_flag;
            r_out_rec    <= r_rec_flag;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.out_lin_x      = r_out_vel[0];
    assign o_res.out_lin_y      = r_out_vel[1];
    assign o_res.out_lin_z      = r_out_vel[2];
    assign o_res.out_ang_x      = r_out_vel[3];
    assign o_res.out_ang_y      = r_out_vel[4];
    assign o_res.out_ang_z      = r_out_vel[5];
    assign o_res.source_code    = r_out_source;
    assign o_res.reason_code    = r_out_reason;
    assign o_res.stale_flag     = r_out_stale;
    assign o_res.safety_level   = r_out_saf;
    assign o_res.recovery_level = r_out_rec;

endmodule
